// File: rtl/fps_pkg.sv
// flight phase sequencer package: phase codes, register indexes, config and
// condition structs shared by the pipeline stages; no dependencies
package fps_pkg;

	typedef enum logic [2:0] {
		PH_DISARMED = 3'd0,
		PH_ARMED    = 3'd1,
		PH_BOOST    = 3'd2,
		PH_COAST    = 3'd3,
		PH_LANDED   = 3'd4
	} phase_t;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 30;

	localparam logic [CFG_IDX_W-1:0] CFG_BOOST_LEVEL = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BOOST_HOLD  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COAST_LEVEL = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_COAST_HOLD  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_REST_TOL    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_TILT_LIMIT  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_ARM_HOLD    = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_LANDED_HOLD = 3'd7;

	// one g in q4.12
	localparam logic [15:0] ONE_G    = 16'd4096;
	localparam logic [15:0] HOLD_MAX = 16'hFFFF;

	typedef struct packed {
		logic [15:0] boost_accel_level;
		logic [15:0] boost_hold;
		logic [15:0] coast_accel_level;
		logic [15:0] coast_hold;
		logic [15:0] rest_tolerance;
		logic [29:0] tilt_limit;
		logic [15:0] arm_hold;
		logic [15:0] landed_hold;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		boost_accel_level: 16'd8192,
		boost_hold:        16'd3,
		coast_accel_level: 16'd5325,
		coast_hold:        16'd5,
		rest_tolerance:    16'd614,
		tilt_limit:        30'd2040110,
		arm_hold:          16'd1500,
		landed_hold:       16'd250
	};

	// per-tick condition flags, all evaluated against the current config
	typedef struct packed {
		logic at_rest;
		logic upright;
		logic above_boost;
		logic below_coast;
	} cond_t;

	// one tick's results without the page addresses
	typedef struct packed {
		logic [2:0]  phase;
		logic        wiggle;
		logic        log_write;
		logic [3:0]  log_slot;
		logic [31:0] log_tick;
		logic        flush0;
		logic [7:0]  bytes0;
		logic        has2;
		logic [7:0]  bytes1;
	} tick_rec_t;

endpackage

// File: rtl/fps_cond.sv
// condition stages: squares of the quaternion parts, then the rest, tilt
// and accel level compares; uses fps_pkg
module fps_cond import fps_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic               in_valid,
	input  logic        [15:0] accel_mag,
	input  logic signed [15:0] quat_x,
	input  logic signed [15:0] quat_y,
	input  logic signed [15:0] quat_z,
	input  cfg_t               cfg,
	output logic               valid_s2,
	output cond_t              cond_s2
);

	logic signed [31:0] px, py, pz;
	logic               valid_s1;
	logic [15:0]        accel_s1;
	logic [30:0]        sqx_s1, sqy_s1, sqz_s1;
	logic [31:0]        tilt_sum;
	logic [15:0]        accel_dev;
	cond_t              cond_d;

	assign px = quat_x * quat_x;
	assign py = quat_y * quat_y;
	assign pz = quat_z * quat_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			accel_s1 <= accel_mag;
			sqx_s1   <= px[30:0];
			sqy_s1   <= py[30:0];
			sqz_s1   <= pz[30:0];
			cond_s2  <= cond_d;
		end
	end

	assign tilt_sum  = 32'(sqx_s1) + 32'(sqy_s1) + 32'(sqz_s1);
	assign accel_dev = (accel_s1 >= ONE_G) ? accel_s1 - ONE_G : ONE_G - accel_s1;

	always_comb begin
		cond_d.at_rest     = accel_dev < cfg.rest_tolerance;
		cond_d.upright     = tilt_sum < 32'(cfg.tilt_limit);
		cond_d.above_boost = accel_s1 > cfg.boost_accel_level;
		cond_d.below_coast = accel_s1 < cfg.coast_accel_level;
	end

endmodule

// File: rtl/fps_ctrl.sv
// phase state machine, hold counter, tick counter and log page bookkeeping;
// uses fps_pkg
module fps_ctrl import fps_pkg::*; #(
	parameter int RECORDS_PER_PAGE = 12,
	parameter int PAGE_BYTES       = 256,
	parameter int RECORD_BYTES     = 20,
	parameter int ADDR_BITS        = 24
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  cond_t                cond,
	input  cfg_t                 cfg,
	output tick_rec_t            rec,
	output logic [ADDR_BITS-1:0] addr0,
	output logic [ADDR_BITS-1:0] addr1
);

	localparam logic [ADDR_BITS-1:0] PAGE_STEP = ADDR_BITS'(PAGE_BYTES);
	localparam logic [3:0]           REC_FULL  = 4'(RECORDS_PER_PAGE);

	phase_t               phase_q, phase_d;
	logic [15:0]          hold_q, hold_d, hold_inc, hold_sel;
	logic [31:0]          tick_q, tick_d;
	logic [3:0]           rec_q, rec_d, rec_cur, rec_new;
	logic [ADDR_BITS-1:0] page_q, page_d, page_mid;
	logic                 run_on, run_cond, hit, pre_flush;
	logic [9:0]           bytes_pre, bytes_end;

	assign tick_d   = tick_q + 32'd1;
	assign hold_inc = (hold_q == HOLD_MAX) ? hold_q : hold_q + 16'd1;

	// which run condition and hold length apply in this phase
	always_comb begin
		run_on   = 1'b1;
		run_cond = 1'b0;
		hold_sel = '0;
		case (phase_q)
			PH_DISARMED: begin
				run_cond = cond.at_rest & cond.upright;
				hold_sel = cfg.arm_hold;
			end
			PH_ARMED: begin
				run_cond = cond.above_boost;
				hold_sel = cfg.boost_hold;
			end
			PH_BOOST: begin
				run_cond = cond.below_coast;
				hold_sel = cfg.coast_hold;
			end
			PH_COAST: begin
				run_cond = cond.at_rest;
				hold_sel = cfg.landed_hold;
			end
			default: begin
				run_on = 1'b0;
			end
		endcase
	end

	assign hit    = run_on & run_cond & (hold_inc >= hold_sel);
	assign hold_d = !run_on ? hold_q : ((!run_cond || hit) ? '0 : hold_inc);

	// next state
	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			PH_DISARMED: if (hit) phase_d = PH_ARMED;
			PH_ARMED:    if (hit) phase_d = PH_BOOST;
			PH_BOOST:    if (hit) phase_d = PH_COAST;
			PH_COAST:    if (hit) phase_d = PH_LANDED;
			default:     phase_d = phase_q;
		endcase
	end

	// log bookkeeping inside boost
	assign pre_flush = rec_q >= REC_FULL;
	assign rec_cur   = pre_flush ? '0 : rec_q;
	assign rec_new   = rec_cur + 4'd1;
	assign page_mid  = pre_flush ? page_q + PAGE_STEP : page_q;
	assign bytes_pre = 10'(rec_q) * 10'(RECORD_BYTES);
	assign bytes_end = 10'(rec_new) * 10'(RECORD_BYTES);

	// outputs and datapath updates
	always_comb begin
		rec       = '0;
		rec.phase = phase_d;
		addr0     = '0;
		addr1     = '0;
		rec_d     = rec_q;
		page_d    = page_q;
		case (phase_q)
			PH_DISARMED: begin
				rec.wiggle = hit;
			end
			PH_ARMED: begin
				if (hit) begin
					rec_d  = '0;
					page_d = '0;
				end
			end
			PH_BOOST: begin
				rec.flush0    = pre_flush;
				rec.bytes0    = pre_flush ? bytes_pre[7:0] : '0;
				addr0         = pre_flush ? page_q : '0;
				rec.log_write = 1'b1;
				rec.log_slot  = rec_cur;
				rec.log_tick  = tick_d;
				rec_d         = rec_new;
				page_d        = page_mid;
				if (hit && rec_new != '0) begin
					rec.has2   = 1'b1;
					rec.bytes1 = bytes_end[7:0];
					addr1      = page_mid;
					rec_d      = '0;
					page_d     = page_mid + PAGE_STEP;
				end
			end
			default: begin
				rec_d = rec_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_DISARMED;
			hold_q  <= '0;
			tick_q  <= '0;
			rec_q   <= '0;
			page_q  <= '0;
		end else if (push) begin
			phase_q <= phase_d;
			hold_q  <= hold_d;
			tick_q  <= tick_d;
			rec_q   <= rec_d;
			page_q  <= page_d;
		end
	end

	a_landed_stays: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_LANDED |=> phase_q == PH_LANDED)
		else $error("landed phase left");

	a_wiggle_on_arm: assert property (@(posedge clk) disable iff (!arst_n)
		push && rec.wiggle |=> phase_q == PH_ARMED && hold_q == '0)
		else $error("wiggle without arming");

	a_second_flush: assert property (@(posedge clk) disable iff (!arst_n)
		push && rec.has2 |=> phase_q == PH_COAST && rec_q == '0)
		else $error("second flush outside the move to coast");

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		push && rec.log_write |-> rec.log_slot < REC_FULL)
		else $error("log slot beyond page");

endmodule

// File: rtl/fps_outq.sv
// two-entry tick queue feeding the result port; a tick with a coast flush
// is sent as two result items; uses fps_pkg
module fps_outq import fps_pkg::*; #(
	parameter int ADDR_BITS = 24
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  tick_rec_t            rec,
	input  logic [ADDR_BITS-1:0] addr0,
	input  logic [ADDR_BITS-1:0] addr1,
	output logic                 full,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [2:0]           phase,
	output logic                 wiggle,
	output logic                 log_write,
	output logic [3:0]           log_slot,
	output logic [31:0]          log_tick,
	output logic                 flush,
	output logic [ADDR_BITS-1:0] flush_page_addr,
	output logic [7:0]           flush_bytes,
	output logic                 last
);

	tick_rec_t            rec_q   [2];
	logic [ADDR_BITS-1:0] addr0_q [2];
	logic [ADDR_BITS-1:0] addr1_q [2];
	logic                 wr_q, rd_q, sub_q, take, pop;
	logic [1:0]           count_q;
	tick_rec_t            head;

	assign head      = rec_q[rd_q];
	assign full      = count_q == 2'd2;
	assign out_valid = count_q != 2'd0;
	assign take      = out_valid & out_ready;
	assign pop       = take & (sub_q | ~head.has2);

	always_ff @(posedge clk) begin
		if (push) begin
			rec_q[wr_q]   <= rec;
			addr0_q[wr_q] <= addr0;
			addr1_q[wr_q] <= addr1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			sub_q   <= 1'b0;
			count_q <= '0;
		end else begin
			if (push)
				wr_q <= ~wr_q;
			if (pop)
				rd_q <= ~rd_q;
			if (pop)
				sub_q <= 1'b0;
			else if (take)
				sub_q <= 1'b1;
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	// second item of a tick carries only the closing flush
	always_comb begin
		phase = head.phase;
		if (sub_q) begin
			wiggle          = 1'b0;
			log_write       = 1'b0;
			log_slot        = '0;
			log_tick        = '0;
			flush           = 1'b1;
			flush_page_addr = addr1_q[rd_q];
			flush_bytes     = head.bytes1;
			last            = 1'b1;
		end else begin
			wiggle          = head.wiggle;
			log_write       = head.log_write;
			log_slot        = head.log_slot;
			log_tick        = head.log_tick;
			flush           = head.flush0;
			flush_page_addr = addr0_q[rd_q];
			flush_bytes     = head.bytes0;
			last            = ~head.has2;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("push into full queue");

	a_sub_needs_pair: assert property (@(posedge clk) disable iff (!arst_n)
		sub_q |-> out_valid && head.has2)
		else $error("second item without a paired tick");

	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		take && !sub_q && head.has2 |=> sub_q && out_valid)
		else $error("closing flush item lost");

endmodule

// File: rtl/flight_phase_sequencer_top.sv
// flight phase sequencer top level: config registers, condition stages,
// phase control and result queue; uses fps_pkg, fps_cond, fps_ctrl, fps_outq
//
//  channel  | handshake             | payload
//  ---------+-----------------------+---------------------------------------------
//  input    | in_valid / in_ready   | accel_mag, quat_x, quat_y, quat_z
//  result   | out_valid / out_ready | phase, wiggle, log_write, log_slot, log_tick,
//           |                       | flush, flush_page_addr, flush_bytes, last
//  config   | cfg_we (no wait)      | cfg_index, cfg_data
//
// one tick item is taken per cycle while in_ready is high; its results are
// offered once they pass the square stage, the compare stage and the phase
// update into the queue; a tick that moves from boost to coast with records
// buffered gives two result items
// the queue holds two ticks; when it is full in_ready drops and every stage holds
// reset clears phase, counters, page address and the pipeline valid bits; config
// registers return to their reset values
module flight_phase_sequencer_top import fps_pkg::*; #(
	parameter int RECORDS_PER_PAGE = 12,
	parameter int PAGE_BYTES       = 256,
	parameter int RECORD_BYTES     = 20,
	parameter int ADDR_BITS        = 24
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// config write port
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// tick items
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [15:0]           accel_mag,
	input  logic signed [15:0]    quat_x,
	input  logic signed [15:0]    quat_y,
	input  logic signed [15:0]    quat_z,
	// result items
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [2:0]            phase,
	output logic                  wiggle,
	output logic                  log_write,
	output logic [3:0]            log_slot,
	output logic [31:0]           log_tick,
	output logic                  flush,
	output logic [ADDR_BITS-1:0]  flush_page_addr,
	output logic [7:0]            flush_bytes,
	output logic                  last
);

	cfg_t                 cfg_q;
	logic                 adv;
	logic                 q_full;
	logic                 valid_s2;
	cond_t                cond_s2;
	tick_rec_t            rec;
	logic [ADDR_BITS-1:0] addr0, addr1;

	// config registers, 16-bit ones take the low 16 bits of the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_BOOST_LEVEL: cfg_q.boost_accel_level <= cfg_data[15:0];
				CFG_BOOST_HOLD:  cfg_q.boost_hold        <= cfg_data[15:0];
				CFG_COAST_LEVEL: cfg_q.coast_accel_level <= cfg_data[15:0];
				CFG_COAST_HOLD:  cfg_q.coast_hold        <= cfg_data[15:0];
				CFG_REST_TOL:    cfg_q.rest_tolerance    <= cfg_data[15:0];
				CFG_TILT_LIMIT:  cfg_q.tilt_limit        <= cfg_data;
				CFG_ARM_HOLD:    cfg_q.arm_hold          <= cfg_data[15:0];
				CFG_LANDED_HOLD: cfg_q.landed_hold       <= cfg_data[15:0];
				default:         cfg_q <= cfg_q;
			endcase
		end
	end

	// whole pipeline moves together whenever the queue has room
	assign adv      = ~q_full;
	assign in_ready = adv;

	fps_cond u_cond (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (in_valid),
		.accel_mag (accel_mag),
		.quat_x    (quat_x),
		.quat_y    (quat_y),
		.quat_z    (quat_z),
		.cfg       (cfg_q),
		.valid_s2  (valid_s2),
		.cond_s2   (cond_s2)
	);

	fps_ctrl #(
		.RECORDS_PER_PAGE (RECORDS_PER_PAGE),
		.PAGE_BYTES       (PAGE_BYTES),
		.RECORD_BYTES     (RECORD_BYTES),
		.ADDR_BITS        (ADDR_BITS)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (adv & valid_s2),
		.cond   (cond_s2),
		.cfg    (cfg_q),
		.rec    (rec),
		.addr0  (addr0),
		.addr1  (addr1)
	);

	fps_outq #(
		.ADDR_BITS (ADDR_BITS)
	) u_outq (
		.clk             (clk),
		.arst_n          (arst_n),
		.push            (adv & valid_s2),
		.rec             (rec),
		.addr0           (addr0),
		.addr1           (addr1),
		.full            (q_full),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.phase           (phase),
		.wiggle          (wiggle),
		.log_write       (log_write),
		.log_slot        (log_slot),
		.log_tick        (log_tick),
		.flush           (flush),
		.flush_page_addr (flush_page_addr),
		.flush_bytes     (flush_bytes),
		.last            (last)
	);

endmodule
